### design/multi_queue_drop_oldest_buffer_macros.svh
// Assertion macros shared by the multi-queue drop-oldest buffer.
`ifndef MULTI_QUEUE_DROP_OLDEST_BUFFER_MACROS_SVH
`define MULTI_QUEUE_DROP_OLDEST_BUFFER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MQDOB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mqdob: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MQDOB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mqdob: next-cycle check failed");

`endif

### design/mqdob_pkg.sv
// Package with types, codes and defaults of the multi-queue drop-oldest buffer.
package mqdob_pkg;

    localparam int NUM_QUEUES_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int CMD_W     = 2;
    localparam int QIDX_W    = 3;
    localparam int KIND_W    = 8;
    localparam int PAYLOAD_W = 32;
    localparam int QCNT_W    = 4;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 56;

    localparam logic [QCNT_W-1:0] QCNT_RESET = 4'd8;

    typedef enum logic [CMD_W-1:0] {
        CMD_BIND = 2'd0,
        CMD_FREE = 2'd1,
        CMD_PUSH = 2'd2,
        CMD_POP  = 2'd3
    } t_cmd_e;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_BOUND = 2'd1,
        ST_RANGE = 2'd2,
        ST_EMPTY = 2'd3
    } t_status_e;

    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload;
        logic [KIND_W-1:0]    minor;
        logic [KIND_W-1:0]    major;
    } t_entry;

    typedef struct packed {
        t_status_e status;
        logic      stored;
        logic      dropped;
        logic      pop_hit;
    } t_result;

endpackage

### design/mqdob_store.sv
// Entry store: one write or one read per cycle, registered read data.
module mqdob_store #(
    parameter int NUM_QUEUES  = mqdob_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = mqdob_pkg::QUEUE_DEPTH_DEF,
    parameter int QW          = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
    parameter int PW          = $clog2(QUEUE_DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic               i_rd_en,
    input  logic [QW-1:0]      i_q,
    input  logic [PW-1:0]      i_ptr,
    input  mqdob_pkg::t_entry  i_wdata,
    output mqdob_pkg::t_entry  o_rdata
);
    import mqdob_pkg::*;

    t_entry r_mem [NUM_QUEUES][QUEUE_DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_q][i_ptr] <= i_wdata;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_q][i_ptr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/mqdob_ctrl.sv
// Per-queue control: bound flags, head pointers, fill counts and command decode.
module mqdob_ctrl #(
    parameter int NUM_QUEUES  = mqdob_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = mqdob_pkg::QUEUE_DEPTH_DEF,
    parameter int QW          = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
    parameter int PW          = $clog2(QUEUE_DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mqdob_pkg::QCNT_W-1:0]  i_cfg_wdata,
    input  logic                          i_exec,
    input  mqdob_pkg::t_cmd_e             i_cmd,
    input  logic [mqdob_pkg::QIDX_W-1:0]  i_qidx,
    output mqdob_pkg::t_result            o_res,
    output logic                          o_wr_en,
    output logic                          o_rd_en,
    output logic [QW-1:0]                 o_q,
    output logic [PW-1:0]                 o_ptr
);
    import mqdob_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
    localparam logic [SW-1:0] DEPTH_S  = SW'(QUEUE_DEPTH);
    localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);

    logic [QCNT_W-1:0] r_qcnt;
    logic              r_bound [NUM_QUEUES];
    logic [PW-1:0]     r_head  [NUM_QUEUES];
    logic [CW-1:0]     r_fill  [NUM_QUEUES];

    logic          n_bound;
    logic [PW-1:0] n_head;
    logic [CW-1:0] n_fill;
    logic          upd;
    logic          in_range;
    logic [QW-1:0] q;
    logic          cur_bound;
    logic [PW-1:0] cur_head;
    logic [CW-1:0] cur_fill;
    logic [SW-1:0] sum;
    logic [PW-1:0] tail;
    logic [PW-1:0] head_inc;
    t_result       res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qcnt <= QCNT_RESET;
        end else if (i_cfg_we) begin
            r_qcnt <= i_cfg_wdata;
        end
    end

    assign in_range = ({1'b0, i_qidx} < r_qcnt) && (int'(i_qidx) < NUM_QUEUES);
    assign q        = QW'(i_qidx);

    assign cur_bound = r_bound[q];
    assign cur_head  = r_head[q];
    assign cur_fill  = r_fill[q];

    assign sum      = SW'(cur_head) + SW'(cur_fill);
    assign tail     = (sum >= DEPTH_S) ? PW'(sum - DEPTH_S) : PW'(sum);
    assign head_inc = (cur_head == LAST_PTR) ? '0 : cur_head + 1'b1;

    always_comb begin
        res         = '{status: ST_OK, stored: 1'b0, dropped: 1'b0, pop_hit: 1'b0};
        n_bound     = cur_bound;
        n_head      = cur_head;
        n_fill      = cur_fill;
        o_wr_en     = 1'b0;
        o_rd_en     = 1'b0;
        o_ptr       = cur_head;
        upd         = 1'b0;
        if (!in_range) begin
            res.status = ST_RANGE;
        end else begin
            case (i_cmd)
                CMD_BIND: begin
                    if (cur_bound) begin
                        res.status = ST_BOUND;
                    end else begin
                        n_bound = 1'b1;
                        upd     = 1'b1;
                    end
                end
                CMD_FREE: begin
                    n_bound = 1'b0;
                    n_head  = '0;
                    n_fill  = '0;
                    upd     = 1'b1;
                end
                CMD_PUSH: begin
                    if (cur_bound) begin
                        res.stored = 1'b1;
                        o_wr_en    = i_exec;
                        o_ptr      = tail;
                        upd        = 1'b1;
                        if (cur_fill == FULL_CNT) begin
                            res.dropped = 1'b1;
                            n_head      = head_inc;
                        end else begin
                            n_fill = cur_fill + 1'b1;
                        end
                    end
                end
                CMD_POP: begin
                    if (cur_fill == '0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        res.pop_hit = 1'b1;
                        o_rd_en     = i_exec;
                        n_head      = head_inc;
                        n_fill      = cur_fill - 1'b1;
                        upd         = 1'b1;
                    end
                end
                default: begin
                    res.status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_bound[i] <= 1'b0;
                r_head[i]  <= '0;
                r_fill[i]  <= '0;
            end
        end else if (i_exec && upd) begin
            r_bound[q] <= n_bound;
            r_head[q]  <= n_head;
            r_fill[q]  <= n_fill;
        end
    end

    assign o_res = res;
    assign o_q   = q;

endmodule

### design/multi_queue_drop_oldest_buffer.sv
// An accepted beat moves from the input register into the result register.
// Throughput: one command per cycle unless the output stalls; each queue's flag,
// head and fill are read, updated and written back in one stage.
// Reset clears all bound flags, head pointers and fill counts and sets the queue
// count to eight; the entry store is not cleared and needs no clearing pass.
// Top level: input register, queue control, entry store and result register.
module multi_queue_drop_oldest_buffer #(
    parameter int NUM_QUEUES  = mqdob_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = mqdob_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mqdob_pkg::QCNT_W-1:0]     i_cfg_wdata,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // cmd, queue_index, major_kind, minor_kind, payload_handle, zero fill
    input  logic [mqdob_pkg::S_TDATA_W-1:0]  i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // status, stored, dropped_oldest, out_major, out_minor, out_payload, zero fill
    output logic [mqdob_pkg::M_TDATA_W-1:0]  o_m_tdata
);
    import mqdob_pkg::*;

    `include "multi_queue_drop_oldest_buffer_macros.svh"

    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PW = $clog2(QUEUE_DEPTH);

    logic                r_a_vld;
    t_cmd_e              r_a_cmd;
    logic [QIDX_W-1:0]   r_a_qidx;
    t_entry              r_a_entry;
    logic                r_b_vld;
    t_result             r_b_res;

    logic                advance;
    logic                exec;
    t_result             res;
    logic                wr_en;
    logic                rd_en;
    logic [QW-1:0]       mem_q;
    logic [PW-1:0]       mem_ptr;
    t_entry              rdata;
    t_entry              out_entry;

    assign advance    = !r_b_vld || i_m_tready;
    assign exec       = r_a_vld && advance;
    assign o_s_tready = !r_a_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_a_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_a_cmd           <= t_cmd_e'(i_s_tdata[1:0]);
            r_a_qidx          <= i_s_tdata[4:2];
            r_a_entry.major   <= i_s_tdata[12:5];
            r_a_entry.minor   <= i_s_tdata[20:13];
            r_a_entry.payload <= i_s_tdata[52:21];
        end
    end

    mqdob_ctrl #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .QW          (QW),
        .PW          (PW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_exec      (exec),
        .i_cmd       (r_a_cmd),
        .i_qidx      (r_a_qidx),
        .o_res       (res),
        .o_wr_en     (wr_en),
        .o_rd_en     (rd_en),
        .o_q         (mem_q),
        .o_ptr       (mem_ptr)
    );

    mqdob_store #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .QW          (QW),
        .PW          (PW)
    ) u_store (
        .i_clk   (i_clk),
        .i_wr_en (wr_en),
        .i_rd_en (rd_en),
        .i_q     (mem_q),
        .i_ptr   (mem_ptr),
        .i_wdata (r_a_entry),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (advance) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_b_res <= res;
        end
    end

    assign out_entry  = r_b_res.pop_hit ? rdata : '0;
    assign o_m_tvalid = r_b_vld;
    assign o_m_tdata  = {4'b0000, out_entry.payload, out_entry.minor, out_entry.major,
                         r_b_res.dropped, r_b_res.stored, r_b_res.status};

    `MQDOB_ASSERT_SAME(a_drop_needs_store, r_b_vld && r_b_res.dropped, r_b_res.stored)
    `MQDOB_ASSERT_SAME(a_store_is_ok, r_b_vld && (r_b_res.stored || r_b_res.pop_hit), r_b_res.status == ST_OK)
    `MQDOB_ASSERT_SAME(a_mem_one_port, 1'b1, !(wr_en && rd_en))
    `MQDOB_ASSERT_NEXT(a_exec_fills_result, exec, r_b_vld)

endmodule
